// File: hw/rtl/assert_macros.svh
// Assertion macros for the serial shifter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BCSS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bcss assertion failed");
`define BCSS_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("bcss forbidden condition seen");
`else
`define BCSS_ASSERT(lbl, prop)
`define BCSS_NEVER(lbl, expr)
`endif
`endif

// File: hw/rtl/bcss_pkg.sv
// Shared constants, command codes and types of the serial shifter.
package bcss_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned ReportBytes = 24;
  localparam int unsigned BytesLeftW  = 5;
  localparam int unsigned PulseCntW   = 4;
  localparam int unsigned MaxPulses   = 8;

  // header codes
  localparam logic [ByteW-1:0] HdrNop  = 8'h00;
  localparam logic [ByteW-1:0] HdrCtrl = 8'h80;
  localparam logic [ByteW-1:0] HdrLenMask = 8'h7f;

  // control codes
  localparam logic [ByteW-1:0] CtlSelLo   = 8'h00;
  localparam logic [ByteW-1:0] CtlSelHi   = 8'h01;
  localparam logic [ByteW-1:0] CtlClkLo   = 8'h02;
  localparam logic [ByteW-1:0] CtlClkHi   = 8'h03;
  localparam logic [ByteW-1:0] CtlDatLo   = 8'h04;
  localparam logic [ByteW-1:0] CtlDatHi   = 8'h05;
  localparam logic [ByteW-1:0] CtlQLevel  = 8'h06;
  localparam logic [ByteW-1:0] CtlDelayRd = 8'h7f;
  localparam logic [ByteW-1:0] DelayBias  = 8'h80;

  // pin positions in the pin level register
  localparam int unsigned PinS = 2;
  localparam int unsigned PinC = 1;
  localparam int unsigned PinD = 0;

  localparam logic [2:0]       PinsReset  = 3'b111;
  localparam logic [ByteW-1:0] DelayReset = 8'h01;

  typedef struct packed {
    logic                 load;
    logic                 step;
    logic                 write_mode;
    logic [PulseCntW-1:0] pulses;
  } shift_ctl_t;

  typedef struct packed {
    logic bit_out;
    logic last;
  } shift_sts_t;

endpackage

// File: hw/rtl/bcss_in_if.sv
// Input channel: host word plus the sampled Q line.
interface bcss_in_if;
  import bcss_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] host_byte;
  logic             report_start;
  logic [ByteW-1:0] q_bits;
  logic             q_level;

  modport source (output valid, host_byte, report_start, q_bits, q_level, input ready);
  modport sink   (input valid, host_byte, report_start, q_bits, q_level, output ready);
endinterface

// File: hw/rtl/bcss_out_if.sv
// Output channel: reply word and pin activity of one host word.
interface bcss_out_if;
  import bcss_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ByteW-1:0]     reply_byte;
  logic [PulseCntW-1:0] pulse_count;
  logic [ByteW-1:0]     driven_bits;
  logic                 select_level;
  logic                 clock_level;
  logic                 data_level;
  logic [ByteW-1:0]     half_period;
  logic                 last_of_report;

  modport source (output valid, reply_byte, pulse_count, driven_bits, select_level,
                  clock_level, data_level, half_period, last_of_report, input ready);
  modport sink   (input valid, reply_byte, pulse_count, driven_bits, select_level,
                  clock_level, data_level, half_period, last_of_report, output ready);
endinterface

// File: hw/rtl/bcss_shifter.sv
// Shared bit shifter: one D bit out and one Q sample in per clock pulse.
module bcss_shifter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bcss_pkg::shift_ctl_t        ctl_i,
  input  logic [bcss_pkg::ByteW-1:0]  host_byte_i,
  input  logic [bcss_pkg::ByteW-1:0]  q_bits_i,
  input  logic                        d_level_i,
  output bcss_pkg::shift_sts_t        sts_o,
  output logic [bcss_pkg::ByteW-1:0]  rx_o,
  output logic [bcss_pkg::ByteW-1:0]  driven_o
);
  import bcss_pkg::*;

  logic [ByteW-1:0]     sr_q, sr_d;
  logic [ByteW-1:0]     qb_q, qb_d;
  logic [ByteW-1:0]     drv_q, drv_d;
  logic [2:0]           idx_q, idx_d;
  logic [PulseCntW-1:0] left_q, left_d;
  logic                 wr_q, wr_d;
  logic                 dlev_q, dlev_d;

  always_comb begin
    sr_d   = sr_q;
    qb_d   = qb_q;
    drv_d  = drv_q;
    idx_d  = idx_q;
    left_d = left_q;
    wr_d   = wr_q;
    dlev_d = dlev_q;
    if (ctl_i.load) begin
      sr_d   = ctl_i.write_mode ? host_byte_i : '0;
      qb_d   = q_bits_i;
      drv_d  = '0;
      idx_d  = '0;
      left_d = ctl_i.pulses;
      wr_d   = ctl_i.write_mode;
      dlev_d = d_level_i;
    end else if (ctl_i.step) begin
      // pulse idx drives bit 7-idx and samples Q into bit 0
      drv_d[~idx_d] = wr_q ? sr_q[ByteW-1] : dlev_q;
      sr_d          = {sr_q[ByteW-2:0], qb_q[~idx_q]};
      idx_d         = 3'(idx_q + 3'd1);
      left_d        = PulseCntW'(left_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q   <= '0;
      qb_q   <= '0;
      drv_q  <= '0;
      idx_q  <= '0;
      left_q <= '0;
      wr_q   <= 1'b0;
      dlev_q <= 1'b0;
    end else begin
      sr_q   <= sr_d;
      qb_q   <= qb_d;
      drv_q  <= drv_d;
      idx_q  <= idx_d;
      left_q <= left_d;
      wr_q   <= wr_d;
      dlev_q <= dlev_d;
    end
  end

  assign sts_o.bit_out = sr_q[ByteW-1];
  assign sts_o.last    = (left_q == PulseCntW'(1));
  assign rx_o          = sr_q;
  assign driven_o      = drv_q;

endmodule

// File: hw/rtl/bcss_ctrl.sv
// Command decoder and pulse sequencer with the result register.
`include "assert_macros.svh"
module bcss_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bcss_in_if.sink                     in_i,
  bcss_out_if.source                  out_o,
  output bcss_pkg::shift_ctl_t        shift_ctl_o,
  output logic                        d_level_o,
  input  bcss_pkg::shift_sts_t        shift_sts_i,
  input  logic [bcss_pkg::ByteW-1:0]  rx_i,
  input  logic [bcss_pkg::ByteW-1:0]  driven_i
);
  import bcss_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StLow,
    StHigh,
    StDone
  } state_e;

  state_e state_q, state_d;

  logic [BytesLeftW-1:0] bytes_q, bytes_d;
  logic [ByteW-1:0]      rbl_q, rbl_d;
  logic [ByteW-1:0]      wbl_q, wbl_d;
  logic                  armed_q, armed_d;
  logic [2:0]            pins_q, pins_d;
  logic [ByteW-1:0]      delay_q, delay_d;
  logic [ByteW-1:0]      reply_q, reply_d;
  logic                  rx_sel_q, rx_sel_d;
  logic                  wr_q, wr_d;
  logic [PulseCntW-1:0]  pulses_q, pulses_d;
  logic                  last_q, last_d;

  // result register
  logic                  ov_q, ov_d;
  logic [ByteW-1:0]      o_reply_q, o_reply_d;
  logic [PulseCntW-1:0]  o_pulses_q, o_pulses_d;
  logic [ByteW-1:0]      o_drv_q, o_drv_d;
  logic [2:0]            o_pins_q, o_pins_d;
  logic [ByteW-1:0]      o_delay_q, o_delay_d;
  logic                  o_last_q, o_last_d;

  logic                  accept;
  logic [BytesLeftW-1:0] eff_bytes;
  logic [ByteW-1:0]      eff_rbl, eff_wbl;
  logic                  eff_armed;
  logic [PulseCntW-1:0]  n_rd, n_wr;
  logic [ByteW-1:0]      b;

  assign in_i.ready = (state_q == StIdle);
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.host_byte;

  assign eff_bytes = in_i.report_start ? BytesLeftW'(ReportBytes) : bytes_q;
  assign eff_rbl   = in_i.report_start ? '0 : rbl_q;
  assign eff_wbl   = in_i.report_start ? '0 : wbl_q;
  assign eff_armed = in_i.report_start ? 1'b0 : armed_q;
  assign n_rd = (eff_rbl >= ByteW'(MaxPulses)) ? PulseCntW'(MaxPulses) : eff_rbl[PulseCntW-1:0];
  assign n_wr = (eff_wbl >= ByteW'(MaxPulses)) ? PulseCntW'(MaxPulses) : eff_wbl[PulseCntW-1:0];

  always_comb begin
    state_d    = state_q;
    bytes_d    = bytes_q;
    rbl_d      = rbl_q;
    wbl_d      = wbl_q;
    armed_d    = armed_q;
    pins_d     = pins_q;
    delay_d    = delay_q;
    reply_d    = reply_q;
    rx_sel_d   = rx_sel_q;
    wr_d       = wr_q;
    pulses_d   = pulses_q;
    last_d     = last_q;
    ov_d       = ov_q;
    o_reply_d  = o_reply_q;
    o_pulses_d = o_pulses_q;
    o_drv_d    = o_drv_q;
    o_pins_d   = o_pins_q;
    o_delay_d  = o_delay_q;
    o_last_d   = o_last_q;
    shift_ctl_o = '0;

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (accept && (eff_bytes != '0)) begin
          bytes_d  = BytesLeftW'(eff_bytes - 1'b1);
          last_d   = (eff_bytes == BytesLeftW'(1));
          rbl_d    = eff_rbl;
          wbl_d    = eff_wbl;
          armed_d  = eff_armed;
          reply_d  = b;
          rx_sel_d = 1'b0;
          wr_d     = 1'b0;
          pulses_d = '0;
          if (eff_rbl != '0) begin
            pulses_d = n_rd;
            rbl_d    = ByteW'(eff_rbl - {{(ByteW-PulseCntW){1'b0}}, n_rd});
            rx_sel_d = 1'b1;
          end else if (eff_armed) begin
            armed_d = 1'b0;
            case (b)
              CtlSelLo:   pins_d[PinS] = 1'b0;
              CtlSelHi:   pins_d[PinS] = 1'b1;
              CtlClkLo:   pins_d[PinC] = 1'b0;
              CtlClkHi:   pins_d[PinC] = 1'b1;
              CtlDatLo:   pins_d[PinD] = 1'b0;
              CtlDatHi:   pins_d[PinD] = 1'b1;
              CtlQLevel:  reply_d = {{(ByteW-1){1'b0}}, in_i.q_level};
              CtlDelayRd: reply_d = delay_q;
              default:    delay_d = ByteW'(b - DelayBias);
            endcase
          end else if (eff_wbl != '0) begin
            pulses_d = n_wr;
            wbl_d    = ByteW'(eff_wbl - {{(ByteW-PulseCntW){1'b0}}, n_wr});
            wr_d     = 1'b1;
          end else begin
            if (b == HdrCtrl) begin
              armed_d = 1'b1;
            end else if (b == HdrNop) begin
              armed_d = 1'b0;
            end else if (b[ByteW-1]) begin
              wbl_d = ByteW'((b & HdrLenMask) + 8'd1);
            end else begin
              rbl_d = ByteW'(b + 8'd1);
            end
          end
          shift_ctl_o.load       = 1'b1;
          shift_ctl_o.write_mode = (eff_rbl == '0) && !eff_armed;
          shift_ctl_o.pulses     = pulses_d;
          state_d = (pulses_d != '0) ? StLow : StDone;
        end
      end
      StLow: begin
        pins_d[PinC] = 1'b0;
        if (wr_q) begin
          pins_d[PinD] = shift_sts_i.bit_out;
        end
        state_d = StHigh;
      end
      StHigh: begin
        pins_d[PinC]     = 1'b1;
        shift_ctl_o.step = 1'b1;
        state_d = shift_sts_i.last ? StDone : StLow;
      end
      StDone: begin
        if (!ov_q || out_o.ready) begin
          ov_d       = 1'b1;
          o_reply_d  = rx_sel_q ? rx_i : reply_q;
          o_pulses_d = pulses_q;
          o_drv_d    = (pulses_q != '0) ? driven_i : '0;
          o_pins_d   = pins_q;
          o_delay_d  = delay_q;
          o_last_d   = last_q;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      bytes_q    <= '0;
      rbl_q      <= '0;
      wbl_q      <= '0;
      armed_q    <= 1'b0;
      pins_q     <= PinsReset;
      delay_q    <= DelayReset;
      reply_q    <= '0;
      rx_sel_q   <= 1'b0;
      wr_q       <= 1'b0;
      pulses_q   <= '0;
      last_q     <= 1'b0;
      ov_q       <= 1'b0;
      o_reply_q  <= '0;
      o_pulses_q <= '0;
      o_drv_q    <= '0;
      o_pins_q   <= PinsReset;
      o_delay_q  <= DelayReset;
      o_last_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      bytes_q    <= bytes_d;
      rbl_q      <= rbl_d;
      wbl_q      <= wbl_d;
      armed_q    <= armed_d;
      pins_q     <= pins_d;
      delay_q    <= delay_d;
      reply_q    <= reply_d;
      rx_sel_q   <= rx_sel_d;
      wr_q       <= wr_d;
      pulses_q   <= pulses_d;
      last_q     <= last_d;
      ov_q       <= ov_d;
      o_reply_q  <= o_reply_d;
      o_pulses_q <= o_pulses_d;
      o_drv_q    <= o_drv_d;
      o_pins_q   <= o_pins_d;
      o_delay_q  <= o_delay_d;
      o_last_q   <= o_last_d;
    end
  end

  assign d_level_o = pins_q[PinD];

  assign out_o.valid          = ov_q;
  assign out_o.reply_byte     = o_reply_q;
  assign out_o.pulse_count    = o_pulses_q;
  assign out_o.driven_bits    = o_drv_q;
  assign out_o.select_level   = o_pins_q[PinS];
  assign out_o.clock_level    = o_pins_q[PinC];
  assign out_o.data_level     = o_pins_q[PinD];
  assign out_o.half_period    = o_delay_q;
  assign out_o.last_of_report = o_last_q;

  `BCSS_ASSERT(a_low_then_high, (state_q == StLow) |=> (state_q == StHigh))
  `BCSS_ASSERT(a_high_leaves_c_up, (state_q == StHigh) |=> pins_q[PinC])
  `BCSS_ASSERT(a_last_pulse_done, (state_q == StHigh) && shift_sts_i.last |=> (state_q == StDone))
  `BCSS_ASSERT(a_result_from_done, $rose(ov_q) |-> $past(state_q == StDone))
  `BCSS_NEVER(a_pulse_bound, ov_q && (o_pulses_q > PulseCntW'(MaxPulses)))

endmodule

// File: hw/rtl/byte_command_serial_shifter.sv
// Byte command serial shifter: decodes host words and clocks bits on S/C/D.
// Each host word on in_i gives one result word on out_o, unless it falls beyond the
// current report (then it is dropped). A header, control or echoed word goes from
// idle straight to the done state; a data word that clocks n pulses (n up to 8)
// passes through a low and a high C state for each pulse before the done state,
// and the shared shifter moves one D bit out and one Q sample in per pulse. in_i is
// ready only while the sequencer is idle; a finished result waits in the output
// register and the next word is decoded meanwhile. After reset no report is open,
// so words are dropped until one arrives with report_start set.
module byte_command_serial_shifter (
  input  logic       clk_i,
  input  logic       rst_ni,
  bcss_in_if.sink    in_i,
  bcss_out_if.source out_o
);
  import bcss_pkg::*;

  shift_ctl_t       shift_ctl;
  shift_sts_t       shift_sts;
  logic             d_level;
  logic [ByteW-1:0] rx;
  logic [ByteW-1:0] driven;

  bcss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .shift_ctl_o (shift_ctl),
    .d_level_o   (d_level),
    .shift_sts_i (shift_sts),
    .rx_i        (rx),
    .driven_i    (driven)
  );

  bcss_shifter u_shifter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (shift_ctl),
    .host_byte_i (in_i.host_byte),
    .q_bits_i    (in_i.q_bits),
    .d_level_i   (d_level),
    .sts_o       (shift_sts),
    .rx_o        (rx),
    .driven_o    (driven)
  );

endmodule

// File: tb/bcss_scoreboard_pkg.sv
// Scoreboard class of the serial shifter testbench: word predictor and reply checker.
package bcss_scoreboard_pkg;
  import bcss_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] host_byte;
    logic             report_start;
    logic [ByteW-1:0] q_bits;
    logic             q_level;
  } host_word_t;

  typedef struct packed {
    logic [ByteW-1:0]     reply_byte;
    logic [PulseCntW-1:0] pulse_count;
    logic [ByteW-1:0]     driven_bits;
    logic                 select_level;
    logic                 clock_level;
    logic                 data_level;
    logic [ByteW-1:0]     half_period;
    logic                 last_of_report;
  } reply_word_t;

  class shifter_scoreboard;
    logic [BytesLeftW-1:0] words_left;
    logic [ByteW-1:0]      reads_left;
    logic [ByteW-1:0]      writes_left;
    logic                  ctl_armed;
    logic [2:0]            pins;
    logic [ByteW-1:0]      delay;
    reply_word_t           expected_q[$];
    int unsigned           error_count;

    function new();
      words_left  = '0;
      reads_left  = '0;
      writes_left = '0;
      ctl_armed   = 1'b0;
      pins        = PinsReset;
      delay       = DelayReset;
      error_count = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Works out the reply of one accepted host word, if it causes one.
    function void note_word(host_word_t w);
      reply_word_t r;
      int unsigned n;
      r = '0;
      r.reply_byte = w.host_byte;
      if (w.report_start) begin
        words_left  = BytesLeftW'(ReportBytes);
        reads_left  = '0;
        writes_left = '0;
        ctl_armed   = 1'b0;
      end
      // beyond the report: dropped without a reply
      if (words_left == 0) return;

      if (reads_left != 0) begin
        n = (reads_left < MaxPulses) ? reads_left : MaxPulses;
        r.reply_byte  = w.q_bits >> (8 - n);
        r.pulse_count = PulseCntW'(n);
        // D just holds its level while clocking in
        if (pins[PinD]) r.driven_bits = 8'hff << (8 - n);
        reads_left  = reads_left - ByteW'(n);
        pins[PinC]  = 1'b1;
      end else if (ctl_armed) begin
        case (w.host_byte)
          CtlSelLo:   pins[PinS] = 1'b0;
          CtlSelHi:   pins[PinS] = 1'b1;
          CtlClkLo:   pins[PinC] = 1'b0;
          CtlClkHi:   pins[PinC] = 1'b1;
          CtlDatLo:   pins[PinD] = 1'b0;
          CtlDatHi:   pins[PinD] = 1'b1;
          CtlQLevel:  r.reply_byte = {7'b0, w.q_level};
          CtlDelayRd: r.reply_byte = delay;
          default:    delay = w.host_byte - DelayBias;
        endcase
        ctl_armed = 1'b0;
      end else if (writes_left != 0) begin
        n = (writes_left < MaxPulses) ? writes_left : MaxPulses;
        r.pulse_count = PulseCntW'(n);
        r.driven_bits = w.host_byte & (8'hff << (8 - n));
        pins[PinD]    = w.host_byte[8 - n];
        pins[PinC]    = 1'b1;
        writes_left   = writes_left - ByteW'(n);
      end else begin
        if (w.host_byte == HdrCtrl) ctl_armed = 1'b1;
        else if (w.host_byte == HdrNop) ctl_armed = 1'b0;
        else if (w.host_byte[7]) writes_left = (w.host_byte & HdrLenMask) + 8'd1;
        else reads_left = w.host_byte + 8'd1;
      end

      words_left       = words_left - 1'b1;
      r.select_level   = pins[PinS];
      r.clock_level    = pins[PinC];
      r.data_level     = pins[PinD];
      r.half_period    = delay;
      r.last_of_report = (words_left == 0);
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
    endtask

    task check_reply(reply_word_t got);
      reply_word_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("reply word %h with none expected", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.reply_byte !== want.reply_byte)
        report_mismatch($sformatf("reply_byte %h, want %h", got.reply_byte, want.reply_byte));
      if (got.pulse_count !== want.pulse_count)
        report_mismatch($sformatf("pulse_count %0d, want %0d", got.pulse_count,
                                  want.pulse_count));
      if (got.driven_bits !== want.driven_bits)
        report_mismatch($sformatf("driven_bits %h, want %h", got.driven_bits,
                                  want.driven_bits));
      if (got.select_level !== want.select_level)
        report_mismatch($sformatf("select_level %b, want %b", got.select_level,
                                  want.select_level));
      if (got.clock_level !== want.clock_level)
        report_mismatch($sformatf("clock_level %b, want %b", got.clock_level,
                                  want.clock_level));
      if (got.data_level !== want.data_level)
        report_mismatch($sformatf("data_level %b, want %b", got.data_level, want.data_level));
      if (got.half_period !== want.half_period)
        report_mismatch($sformatf("half_period %h, want %h", got.half_period,
                                  want.half_period));
      if (got.last_of_report !== want.last_of_report)
        report_mismatch($sformatf("last_of_report %b, want %b", got.last_of_report,
                                  want.last_of_report));
    endtask
  endclass

endpackage

// File: tb/byte_command_serial_shifter_tb.sv
// Top testbench of the serial shifter: stimulus, idling phases, monitor and end of run.
module byte_command_serial_shifter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bcss_pkg::*;
  import bcss_scoreboard_pkg::*;

  localparam int unsigned CycleLimit = 500_000;
  localparam int unsigned PhaseWords = 165;

  logic clk_i;
  logic rst_ni;

  bcss_in_if  in_if ();
  bcss_out_if out_if ();

  byte_command_serial_shifter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  shifter_scoreboard sb;
  host_word_t        word_q[$];
  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;
  int unsigned       report_pos;
  int unsigned       report_len;
  int unsigned       words_made;
  int unsigned       cycle_count;

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.host_byte = '0;
    in_if.report_start = 1'b0;
    in_if.q_bits = '0;
    in_if.q_level = 1'b0;
    out_if.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cycle_count = 0;
    words_made = 0;
    sb = new();
  end

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) out_if.ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_reply('{out_if.reply_byte, out_if.pulse_count, out_if.driven_bits,
                       out_if.select_level, out_if.clock_level, out_if.data_level,
                       out_if.half_period, out_if.last_of_report});
  end

  task automatic push_word(logic [7:0] b, logic start, logic [7:0] q, logic ql);
    word_q.push_back('{b, start, q, ql});
  endtask

  // Adds a word of the current report; words past its cut are left out.
  task automatic put(logic [7:0] b);
    if (report_pos < report_len) begin
      push_word(b, report_pos == 0, 8'($urandom_range(255)), 1'($urandom_range(1)));
      report_pos++;
      words_made++;
    end
  endtask

  function automatic int unsigned pick_bits();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(2, 16);
    if (r < 95) return $urandom_range(17, 64);
    return $urandom_range(65, 128);
  endfunction

  task automatic add_report();
    int unsigned kind;
    int unsigned bits;
    report_pos = 0;
    // some reports are cut short by the next report start
    report_len = ($urandom_range(99) < 12) ? $urandom_range(1, ReportBytes - 1) : ReportBytes;
    while (report_pos < report_len) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        put(HdrCtrl);
        case ($urandom_range(9))
          0: put(CtlSelLo);
          1: put(CtlSelHi);
          2: put(CtlClkLo);
          3: put(CtlClkHi);
          4: put(CtlDatLo);
          5: put(CtlDatHi);
          6: put(CtlQLevel);
          7: put(CtlDelayRd);
          default: put(8'($urandom_range(255)));
        endcase
      end else if (kind < 55) begin
        bits = pick_bits();
        put(HdrCtrl | 8'(bits - 1));
        repeat ((bits + 7) / 8) put(8'($urandom_range(255)));
      end else if (kind < 85) begin
        bits = pick_bits();
        put(8'(bits - 1));
        repeat ((bits + 7) / 8) put(8'($urandom_range(255)));
      end else if (kind < 90) begin
        put(HdrNop);
      end else begin
        put(8'($urandom_range(255)));
      end
    end
    // trailing words beyond a full report are dropped by the block
    if (report_len == ReportBytes && $urandom_range(99) < 15)
      repeat ($urandom_range(1, 3))
        push_word(8'($urandom_range(255)), 1'b0, 8'($urandom_range(255)),
                  1'($urandom_range(1)));
  endtask

  task automatic send_word(host_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.host_byte    <= w.host_byte;
    in_if.report_start <= w.report_start;
    in_if.q_bits       <= w.q_bits;
    in_if.q_level      <= w.q_level;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_word(w);
  endtask

  task automatic drive_all();
    while (word_q.size() != 0) send_word(word_q.pop_front());
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: no report open yet, every control code, delay extremes,
    // partial pulse words, report end and a report cut short by the next start
    push_word(8'h55, 1'b0, 8'h00, 1'b0);
    push_word(HdrCtrl, 1'b1, 8'hff, 1'b0);
    push_word(CtlDelayRd, 1'b0, 8'h00, 1'b0);
    push_word(HdrCtrl, 1'b0, 8'h00, 1'b0);
    push_word(CtlSelLo, 1'b0, 8'h00, 1'b0);
    push_word(HdrCtrl, 1'b0, 8'h00, 1'b0);
    push_word(CtlClkLo, 1'b0, 8'h00, 1'b0);
    push_word(HdrCtrl, 1'b0, 8'h00, 1'b0);
    push_word(CtlDatLo, 1'b0, 8'h00, 1'b0);
    push_word(HdrCtrl, 1'b0, 8'h00, 1'b0);
    push_word(CtlQLevel, 1'b0, 8'h00, 1'b1);
    push_word(HdrCtrl, 1'b0, 8'h00, 1'b0);
    push_word(8'hff, 1'b0, 8'h00, 1'b0);
    push_word(HdrNop, 1'b0, 8'h00, 1'b0);
    push_word(8'h8a, 1'b0, 8'h00, 1'b0);
    push_word(8'ha5, 1'b0, 8'h00, 1'b0);
    push_word(8'he0, 1'b0, 8'h00, 1'b0);
    push_word(8'h0a, 1'b0, 8'h00, 1'b0);
    push_word(8'h3c, 1'b0, 8'hff, 1'b0);
    push_word(8'h00, 1'b0, 8'h5a, 1'b0);
    push_word(HdrCtrl, 1'b0, 8'h00, 1'b0);
    push_word(HdrCtrl, 1'b0, 8'h00, 1'b0);
    push_word(8'hff, 1'b0, 8'h00, 1'b0);
    push_word(8'hff, 1'b0, 8'h00, 1'b0);
    push_word(8'h00, 1'b0, 8'h00, 1'b0);
    push_word(8'h7f, 1'b1, 8'h00, 1'b0);
    push_word(8'h00, 1'b0, 8'hff, 1'b1);
    push_word(HdrCtrl, 1'b1, 8'h00, 1'b0);
    push_word(CtlSelHi, 1'b0, 8'h00, 1'b0);
    push_word(HdrCtrl, 1'b0, 8'h00, 1'b0);
    push_word(CtlClkHi, 1'b0, 8'h00, 1'b0);
    push_word(HdrCtrl, 1'b0, 8'h00, 1'b0);
    push_word(CtlDatHi, 1'b0, 8'h00, 1'b0);
    drive_all();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      words_made = 0;
      while (words_made < PhaseWords) add_report();
      drive_all();
    end

    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    // catch any stray reply after the last expected one
    repeat (40) @(posedge clk_i);
    if (sb.error_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/bcss_pkg.sv
hw/rtl/bcss_in_if.sv
hw/rtl/bcss_out_if.sv
hw/rtl/bcss_shifter.sv
hw/rtl/bcss_ctrl.sv
hw/rtl/byte_command_serial_shifter.sv
tb/bcss_scoreboard_pkg.sv
tb/byte_command_serial_shifter_tb.sv
